>>> src/adj_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adj_pkg
// shared types, codes and constants of the adjacency list edge store
// ----------------------------------------------------------------------------
package adj_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 16;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int ODEG_W   = 5;
    localparam int TOTAL_W  = 11;
    localparam int VC_W     = 7;

    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [VERTEX_W-1:0] source_vertex;
        logic [VERTEX_W-1:0] target_vertex;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                edge_found;
        logic [ODEG_W-1:0]   out_degree;
        logic [TOTAL_W-1:0]  edge_total;
    } out_item_t;

    typedef struct packed {
        logic                clear_en;
        logic                accept;
        logic                lookup;
        logic                append;
        logic                scan_start;
        logic                scan_step;
        logic                set_result;
        logic [STATUS_W-1:0] result_status;
        logic                result_found;
        logic                load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic src_ok;
        logic dst_ok;
        logic op_query;
        logic deg_full;
        logic deg_zero;
        logic scan_more;
        logic scan_hit;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

>>> src/adj_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adj_cfg
// apb register file holding the vertex count
// ----------------------------------------------------------------------------
module adj_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [adj_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [adj_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [adj_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [adj_pkg::VC_W-1:0]         vertex_count
);
    import adj_pkg::*;

    logic [VC_W-1:0]      vertex_count_reg;
    logic [VC_W-1:0]      vertex_count_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;

    always_comb begin
        vertex_count_next = vertex_count_reg;
        if (wr_en && reg_idx == REG_VERTEX_COUNT) begin
            vertex_count_next = pwdata[VC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VC_RESET;
        end else begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_VERTEX_COUNT: prdata = APB_DATA_W'(vertex_count_reg);
            default:          prdata = '0;
        endcase
    end

    assign vertex_count = vertex_count_reg;

endmodule
`default_nettype wire

>>> src/adj_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adj_ctrl
// sequencer for clearing, lookup, append, successor scan and response
// ----------------------------------------------------------------------------
module adj_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire adj_pkg::dp_sts_t sts,
    output adj_pkg::dp_cmd_t      cmd
);
    import adj_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_LOOKUP  = 5'b00100,
        S_SCAN    = 5'b01000,
        S_RESPOND = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup        = 1'b1;
                cmd.set_result    = 1'b1;
                cmd.result_status = STAT_OK;
                state_next        = S_RESPOND;
                if (!sts.src_ok || !sts.dst_ok) begin
                    cmd.result_status = STAT_RANGE;
                end else if (!sts.op_query) begin
                    if (sts.deg_full) begin
                        cmd.result_status = STAT_FULL;
                    end else begin
                        cmd.append = 1'b1;
                    end
                end else if (!sts.deg_zero) begin
                    cmd.set_result = 1'b0;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.result_status = STAT_OK;
                if (sts.scan_hit) begin
                    cmd.set_result   = 1'b1;
                    cmd.result_found = 1'b1;
                    state_next       = S_RESPOND;
                end else if (sts.scan_more) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    cmd.set_result = 1'b1;
                    state_next     = S_RESPOND;
                end
            end
            S_RESPOND: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> src/adj_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adj_dp
// degree memory, successor memory, edge counter and output register
// ----------------------------------------------------------------------------
module adj_dp #(
    parameter int MAX_VERTICES = adj_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = adj_pkg::DEF_MAX_DEGREE
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [adj_pkg::VC_W-1:0] vertex_count,
    input  wire adj_pkg::in_item_t        s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output adj_pkg::out_item_t            m_data,
    input  wire adj_pkg::dp_cmd_t         cmd,
    output adj_pkg::dp_sts_t              sts
);
    import adj_pkg::*;

    localparam int VI_W       = $clog2(MAX_VERTICES);
    localparam int SLOT_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int SUCC_DEPTH = MAX_VERTICES * (1 << SLOT_W);
    localparam int SA_W       = VI_W + SLOT_W;

    logic [DEG_W-1:0]    deg_mem [MAX_VERTICES];
    logic [VERTEX_W-1:0] succ_mem [SUCC_DEPTH];

    logic [VI_W-1:0]     clr_idx_reg;
    logic                op_reg;
    logic [VI_W-1:0]     src_idx_reg;
    logic [VERTEX_W-1:0] dst_reg;
    logic                src_ok_reg;
    logic                dst_ok_reg;
    logic [DEG_W-1:0]    deg_rdata_reg;
    logic [VERTEX_W-1:0] succ_rdata_reg;
    logic [DEG_W-1:0]    issue_cnt_reg;
    logic [DEG_W-1:0]    res_deg_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_found_reg;
    logic [TOTAL_W-1:0]  edge_cnt_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic [VI_W-1:0]     in_src_idx;
    logic                in_src_ok;
    logic                in_dst_ok;
    logic [DEG_W-1:0]    deg_inc;
    logic                deg_we;
    logic [VI_W-1:0]     deg_waddr;
    logic [DEG_W-1:0]    deg_wdata;
    logic [SLOT_W-1:0]   rd_slot;
    logic [SA_W-1:0]     succ_raddr;
    logic [SA_W-1:0]     succ_waddr;

    assign in_src_idx = VI_W'(s_data.source_vertex);
    assign in_src_ok  = ({1'b0, s_data.source_vertex} < vertex_count)
                        && (32'(s_data.source_vertex) < MAX_VERTICES);
    assign in_dst_ok  = ({1'b0, s_data.target_vertex} < vertex_count)
                        && (32'(s_data.target_vertex) < MAX_VERTICES);

    assign deg_inc   = deg_rdata_reg + DEG_W'(1);
    assign deg_we    = cmd.clear_en | cmd.append;
    assign deg_waddr = cmd.clear_en ? clr_idx_reg : src_idx_reg;
    assign deg_wdata = cmd.clear_en ? '0 : deg_inc;

    assign rd_slot    = cmd.scan_start ? '0 : issue_cnt_reg[SLOT_W-1:0];
    assign succ_raddr = {src_idx_reg, rd_slot};
    assign succ_waddr = {src_idx_reg, deg_rdata_reg[SLOT_W-1:0]};

    // degree memory
    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (cmd.accept) begin
            deg_rdata_reg <= deg_mem[in_src_idx];
        end
    end

    // successor memory
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            succ_mem[succ_waddr] <= dst_reg;
        end
        if (cmd.scan_start || cmd.scan_step) begin
            succ_rdata_reg <= succ_mem[succ_raddr];
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg      <= s_data.operation;
            src_idx_reg <= in_src_idx;
            dst_reg     <= s_data.target_vertex;
            src_ok_reg  <= in_src_ok;
            dst_ok_reg  <= in_dst_ok;
        end
        if (cmd.scan_start) begin
            issue_cnt_reg <= DEG_W'(1);
        end else if (cmd.scan_step) begin
            issue_cnt_reg <= issue_cnt_reg + DEG_W'(1);
        end
        if (cmd.lookup) begin
            if (!src_ok_reg) begin
                res_deg_reg <= '0;
            end else if (cmd.append) begin
                res_deg_reg <= deg_inc;
            end else begin
                res_deg_reg <= deg_rdata_reg;
            end
        end
        if (cmd.set_result) begin
            res_status_reg <= cmd.result_status;
            res_found_reg  <= cmd.result_found;
        end
        if (cmd.load_out) begin
            m_data_reg.status     <= res_status_reg;
            m_data_reg.edge_found <= res_found_reg;
            m_data_reg.out_degree <= ODEG_W'(res_deg_reg);
            m_data_reg.edge_total <= edge_cnt_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            edge_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_en) begin
                clr_idx_reg <= clr_idx_reg + VI_W'(1);
            end
            if (cmd.append) begin
                edge_cnt_reg <= edge_cnt_reg + TOTAL_W'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.clear_done = (clr_idx_reg == VI_W'(MAX_VERTICES - 1));
        sts.src_ok     = src_ok_reg;
        sts.dst_ok     = dst_ok_reg;
        sts.op_query   = (op_reg == OP_QUERY);
        sts.deg_full   = (deg_rdata_reg >= DEG_W'(MAX_DEGREE));
        sts.deg_zero   = (deg_rdata_reg == '0);
        sts.scan_more  = (issue_cnt_reg < deg_rdata_reg);
        sts.scan_hit   = (succ_rdata_reg == dst_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> src/adjacency_list_edge_store_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_list_edge_store_unit
// directed graph edge store with bounded per-vertex successor lists
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives one result transaction. After
// reset the block runs a clearing pass over all MAX_VERTICES entries of the
// degree memory with s_ready low; apb writes are taken during it. An add, or
// any item rejected for range or a full list, passes from acceptance through
// the lookup and respond states to the next acceptance. A query with both
// ids in range and out-degree d above zero (at most MAX_DEGREE) also scans
// the successor memory one entry per cycle through its single read port,
// stopping at the first match or after d entries. A result waits in the
// output register while m_ready is low; the next item is accepted meanwhile,
// and its result is held until that slot frees.
// ----------------------------------------------------------------------------
module adjacency_list_edge_store_unit #(
    parameter int MAX_VERTICES = adj_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = adj_pkg::DEF_MAX_DEGREE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire adj_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output adj_pkg::out_item_t                  m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [adj_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [adj_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [adj_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import adj_pkg::*;

    logic [VC_W-1:0] vertex_count;
    dp_cmd_t         cmd;
    dp_sts_t         sts;

    adj_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count)
    );

    adj_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    adj_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .vertex_count (vertex_count),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
`default_nettype wire

>>> sim/adjacency_list_edge_store_unit_tb.sv
// ----------------------------------------------------------------------------
// adjacency_list_edge_store_unit_tb
// Self-checking bench for the edge store. Add-edge and edge-query
// transactions go in through a valid/ready channel and the vertex count is
// reprogrammed over apb between phases. A bench-side copy of the degree and
// successor lists predicts status, found flag, out-degree and edge total.
// Each returned transaction is checked in order against those predictions.
// Both sides stall at random, the receiver once holds off long enough to back
// up the input, and the phases sweep the vertex count from zero to its top.
// ----------------------------------------------------------------------------
module adjacency_list_edge_store_unit_tb;

    import adj_pkg::*;

    localparam int MAX_V        = DEF_MAX_VERTICES;
    localparam int MAX_D        = DEF_MAX_DEGREE;
    localparam int SETTLE       = MAX_D + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 500;
    localparam int NUM_PHASES   = 9;

    localparam logic [APB_ADDR_W-1:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    in_item_t  edge_ops_to_send [$];
    out_item_t expected_replies [$];

    int                vertex_count_cfg = 64;
    int                degree_of [MAX_V];
    logic [VERTEX_W-1:0] successors [MAX_V][MAX_D];
    logic [TOTAL_W-1:0]  edges_stored = '0;

    out_item_t predicted;
    out_item_t want;
    int failures      = 0;
    int results_seen  = 0;
    int ops_accepted  = 0;
    int found_hits    = 0;
    int full_rejects  = 0;
    int range_rejects = 0;
    int cycles        = 0;
    int hold_left     = 0;
    logic hold_done   = 1'b0;

    int phase_vc [NUM_PHASES] = '{64, 1, 0, 127, 8, 100, 33, 2, 64};
    int phase_n  [NUM_PHASES] = '{300, 60, 30, 250, 150, 200, 200, 60, 350};

    wire steady = (results_seen >= 800) && (results_seen < 1100);

    adjacency_list_edge_store_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic out_item_t apply_edge_op(in_item_t op_in);
        out_item_t r;
        int lim;
        int src;
        int dst;
        int d;
        r   = '0;
        lim = (vertex_count_cfg < MAX_V) ? vertex_count_cfg : MAX_V;
        src = op_in.source_vertex;
        dst = op_in.target_vertex;
        if (src >= lim) begin
            r.status = STAT_RANGE;
        end else begin
            d = degree_of[src];
            if (dst >= lim) begin
                r.status = STAT_RANGE;
            end else if (op_in.operation == OP_ADD) begin
                if (d >= MAX_D) begin
                    r.status = STAT_FULL;
                end else begin
                    successors[src][d] = op_in.target_vertex;
                    d = d + 1;
                    degree_of[src] = d;
                    edges_stored = edges_stored + 1'b1;
                end
            end else begin
                for (int i = 0; i < d; i++)
                    if (successors[src][i] == op_in.target_vertex)
                        r.edge_found = 1'b1;
            end
            r.out_degree = ODEG_W'(d);
        end
        r.edge_total = edges_stored;
        return r;
    endfunction

    function automatic in_item_t mk_op(logic op, int src, int dst);
        in_item_t it;
        it.operation     = op;
        it.source_vertex = VERTEX_W'(src);
        it.target_vertex = VERTEX_W'(dst);
        return it;
    endfunction

    // mostly in-range ids, a small target pool so queries hit often
    function automatic in_item_t random_edge_op(int vc);
        int lim;
        int src;
        int dst;
        int pick;
        lim = (vc < MAX_V) ? vc : MAX_V;
        if (lim > 0 && $urandom_range(0, 99) < 85)
            src = $urandom_range(0, lim - 1);
        else
            src = $urandom_range(0, MAX_V - 1);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            dst = $urandom_range(0, 3);
        else if (pick < 85 && lim > 0)
            dst = $urandom_range(0, lim - 1);
        else
            dst = $urandom_range(0, MAX_V - 1);
        return mk_op(($urandom_range(0, 99) < 55) ? OP_ADD : OP_QUERY, src, dst);
    endfunction

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            rdata = prdata;
        end while (!pready);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_vertex_count(input int value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_VERTEX_COUNT, APB_DATA_W'(value), rd);
        vertex_count_cfg = value;
        apb_access(1'b0, ADDR_VERTEX_COUNT, '0, rd);
        if (rd !== APB_DATA_W'(value)) begin
            failures++;
            if (failures <= 10)
                $display("vertex count readback: got %0d expected %0d", rd, value);
        end
    endtask

    task automatic wait_drained();
        while (edge_ops_to_send.size() != 0 || s_valid || expected_replies.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // driver: presents queued transactions and predicts each one on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted = apply_edge_op(s_data);
                expected_replies.push_back(predicted);
                ops_accepted <= ops_accepted + 1;
                if (predicted.edge_found)
                    found_hits <= found_hits + 1;
                if (predicted.status == STAT_FULL)
                    full_rejects <= full_rejects + 1;
                if (predicted.status == STAT_RANGE)
                    range_rejects <= range_rejects + 1;
            end
            if (!s_valid || s_ready) begin
                if (edge_ops_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
                    s_valid <= 1'b1;
                    s_data  <= edge_ops_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_replies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transaction: status %0d found %0d degree %0d total %0d",
                             m_data.status, m_data.edge_found, m_data.out_degree,
                             m_data.edge_total);
            end else begin
                want = expected_replies.pop_front();
                if (m_data.status !== want.status || m_data.edge_found !== want.edge_found ||
                    m_data.out_degree !== want.out_degree ||
                    m_data.edge_total !== want.edge_total) begin
                    failures++;
                    if (failures <= 10)
                        $display("transaction %0d got/expected: status %0d/%0d found %0d/%0d",
                                 results_seen, m_data.status, want.status,
                                 m_data.edge_found, want.edge_found,
                                 " degree %0d/%0d total %0d/%0d",
                                 m_data.out_degree, want.out_degree,
                                 m_data.edge_total, want.edge_total);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("adjacency_list_edge_store_unit_tb failed");
            $finish;
        end
    end

    initial begin
        logic [APB_DATA_W-1:0] rd;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // fill one list to the limit, then scan it
        edge_ops_to_send.push_back(mk_op(OP_ADD, 63, 63));
        edge_ops_to_send.push_back(mk_op(OP_ADD, 63, 0));
        edge_ops_to_send.push_back(mk_op(OP_ADD, 63, 42));
        for (int i = 1; i <= 13; i++)
            edge_ops_to_send.push_back(mk_op(OP_ADD, 63, i));
        edge_ops_to_send.push_back(mk_op(OP_ADD, 63, 21));
        edge_ops_to_send.push_back(mk_op(OP_QUERY, 63, 63));
        edge_ops_to_send.push_back(mk_op(OP_QUERY, 63, 13));
        edge_ops_to_send.push_back(mk_op(OP_QUERY, 63, 62));
        edge_ops_to_send.push_back(mk_op(OP_QUERY, 0, 0));
        edge_ops_to_send.push_back(mk_op(OP_ADD, 0, 63));
        edge_ops_to_send.push_back(mk_op(OP_QUERY, 0, 63));
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (phase_vc[p] == 8)
                apb_access(1'b1, ADDR_UNMAPPED, 32'd5, rd);
            set_vertex_count(phase_vc[p]);
            for (int n = 0; n < phase_n[p]; n++)
                edge_ops_to_send.push_back(random_edge_op(phase_vc[p]));
            wait_drained();
        end

        if (expected_replies.size() != 0) begin
            failures++;
            $display("%0d transactions never returned", expected_replies.size());
        end
        $display("%0d transactions over %0d vertex-count settings, %0d edges stored",
                 ops_accepted, NUM_PHASES + 1, edges_stored);
        $display("%0d query hits, %0d full-list rejects, %0d range rejects, %0d mismatches",
                 found_hits, full_rejects, range_rejects, failures);
        if (failures == 0) begin
            $display("adjacency_list_edge_store_unit_tb passed");
        end else begin
            $display("adjacency_list_edge_store_unit_tb failed");
        end
        $finish;
    end

endmodule
